@@ hdl/tpt_pkg.sv @@
package tpt_pkg;

  // Counter and history geometry
  localparam int COUNT_WIDTH  = 32;
  localparam int HISTORY_BITS = 13;

  // Fixed field widths
  localparam int PERIOD_W  = 32;
  localparam int TOL_W     = 6;
  localparam int PATTERN_W = 13;
  localparam int PAT_EXT_W = 16;  // widest history the pattern compare supports
  localparam int PROD_W    = COUNT_WIDTH + 8;

  // APB geometry
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 4;

  // Percent scale for the tolerance cross-multiplication
  localparam logic [7:0] PCT_SCALE = 8'd100;

  // Reset values of the configuration registers
  localparam logic [TOL_W-1:0]     TOL_RESET        = 6'd1;
  localparam logic [PATTERN_W-1:0] JACK_PAT_RESET   = 13'd8190;
  localparam logic [PATTERN_W-1:0] BUTTON_PAT_RESET = 13'd7936;

  typedef enum logic [1:0] {
    REQ_TICK   = 2'd0,
    REQ_JACK   = 2'd1,
    REQ_BUTTON = 2'd2
  } req_type_e;

  typedef enum logic [1:0] {
    REG_TOLERANCE  = 2'd0,
    REG_JACK_PAT   = 2'd1,
    REG_BUTTON_PAT = 2'd2
  } reg_idx_e;

  localparam logic PING_JACK   = 1'b0;
  localparam logic PING_BUTTON = 1'b1;

  typedef struct packed {
    logic                ping_detected;
    logic                ping_source;
    logic                period_adopted;
    logic [PERIOD_W-1:0] period_value;
  } result_t;

endpackage

@@ hdl/tpt_tol_check.sv @@
module tpt_tol_check (
  input  logic [tpt_pkg::COUNT_WIDTH-1:0] capture_i,
  input  logic [tpt_pkg::COUNT_WIDTH-1:0] period_i,
  input  logic [tpt_pkg::TOL_W-1:0]       tol_i,
  output logic                            outside_o
);

  logic [7:0]                   scale_hi;
  logic [7:0]                   scale_lo;
  logic [tpt_pkg::PROD_W-1:0]   lhs;
  logic [tpt_pkg::PROD_W-1:0]   bound_hi;
  logic [tpt_pkg::PROD_W-1:0]   bound_lo;

  // Compare 100*c against (100 +/- tol)*p exactly
  assign scale_hi = tpt_pkg::PCT_SCALE + {2'b00, tol_i};
  assign scale_lo = tpt_pkg::PCT_SCALE - {2'b00, tol_i};

  assign lhs      = tpt_pkg::PROD_W'(capture_i) * tpt_pkg::PROD_W'(tpt_pkg::PCT_SCALE);
  assign bound_hi = tpt_pkg::PROD_W'(period_i) * tpt_pkg::PROD_W'(scale_hi);
  assign bound_lo = tpt_pkg::PROD_W'(period_i) * tpt_pkg::PROD_W'(scale_lo);

  assign outside_o = (lhs > bound_hi) || (lhs < bound_lo);

endmodule

@@ hdl/tpt_out_buf.sv @@
module tpt_out_buf (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_stall_o,
  input  tpt_pkg::result_t push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_stall_i,
  output tpt_pkg::result_t pop_data_o
);

  logic             main_valid_q;
  logic             skid_valid_q;
  tpt_pkg::result_t main_q;
  tpt_pkg::result_t skid_q;
  logic             push;
  logic             pop;

  assign push_stall_o = skid_valid_q;
  assign push         = push_valid_i && !skid_valid_q;
  assign pop          = main_valid_q && !pop_stall_i;
  assign pop_valid_o  = main_valid_q;
  assign pop_data_o   = main_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (push) begin
      if (main_valid_q && !pop) begin
        skid_valid_q <= 1'b1;
      end else begin
        main_valid_q <= 1'b1;
      end
    end else if (pop) begin
      main_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        main_q <= skid_q;
      end
    end else if (push) begin
      if (main_valid_q && !pop) begin
        skid_q <= push_data_i;
      end else begin
        main_q <= push_data_i;
      end
    end
  end

endmodule

@@ hdl/tap_clock_period_tracker_core.sv @@
// Tap-tempo clock period tracker.
//
// Input channel (in_valid_i / in_stall_o): one transfer per timer tick, clock
// jack sample or tap button sample (req_type_i), with the raw pin in level_i.
// Output channel (out_valid_o / out_stall_i): one result transfer per input
// transfer, in order: ping flags and the stored period after that item.
// Configuration goes through the APB port: tolerance at 0x0, jack pattern at
// 0x4, button pattern at 0x8; pready is tied high, writes land on the access
// cycle. Write configuration only while no results are outstanding.
// Each result is registered into the output buffer when its input is accepted.
// Throughput: one item per cycle while in_stall_o is low; the state update (history
// shift, pattern compare, saturating counter and the tolerance cross-multiply) is
// combinational between the state registers and the result register.
// A two-entry output buffer absorbs a receiver stall; in_stall_o rises only
// once both entries hold results, and results are never dropped.
// Reset clears histories, elapsed count and period, and restores tolerance 1,
// jack pattern 8190 and button pattern 7936.
module tap_clock_period_tracker_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // APB configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tpt_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [tpt_pkg::APB_DATA_W-1:0] pwdata,
  output logic [tpt_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready,
  // input channel
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [1:0]                     req_type_i,
  input  logic                           level_i,
  // result channel
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           ping_detected_o,
  output logic                           ping_source_o,
  output logic                           period_adopted_o,
  output logic [tpt_pkg::PERIOD_W-1:0]   period_value_o
);

  localparam int CW = tpt_pkg::COUNT_WIDTH;
  localparam int HW = tpt_pkg::HISTORY_BITS;

  // Configuration registers
  logic [tpt_pkg::TOL_W-1:0]     tol_q;
  logic [tpt_pkg::PATTERN_W-1:0] jack_pat_q;
  logic [tpt_pkg::PATTERN_W-1:0] button_pat_q;

  // Tracker state
  logic [HW-1:0] jack_hist_q, jack_hist_d;
  logic [HW-1:0] button_hist_q, button_hist_d;
  logic [CW-1:0] elapsed_q, elapsed_d;
  logic [CW-1:0] period_q, period_d;

  logic                  cfg_write;
  tpt_pkg::reg_idx_e     cfg_idx;
  logic                  accept;
  logic                  outside;
  logic [HW-1:0]         jack_shift;
  logic [HW-1:0]         button_shift;
  logic [tpt_pkg::PAT_EXT_W-1:0] jack_pat_ext;
  logic [tpt_pkg::PAT_EXT_W-1:0] button_pat_ext;
  tpt_pkg::result_t      result;
  tpt_pkg::result_t      out_data;

  // ---------------------------------------------------------------------------
  // APB register file
  // ---------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_idx   = tpt_pkg::reg_idx_e'(paddr[3:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q        <= tpt_pkg::TOL_RESET;
      jack_pat_q   <= tpt_pkg::JACK_PAT_RESET;
      button_pat_q <= tpt_pkg::BUTTON_PAT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_idx)
        tpt_pkg::REG_TOLERANCE:  tol_q        <= pwdata[tpt_pkg::TOL_W-1:0];
        tpt_pkg::REG_JACK_PAT:   jack_pat_q   <= pwdata[tpt_pkg::PATTERN_W-1:0];
        tpt_pkg::REG_BUTTON_PAT: button_pat_q <= pwdata[tpt_pkg::PATTERN_W-1:0];
        default: ;  // unmapped offset: drop the write
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      tpt_pkg::REG_TOLERANCE:  prdata = tpt_pkg::APB_DATA_W'(tol_q);
      tpt_pkg::REG_JACK_PAT:   prdata = tpt_pkg::APB_DATA_W'(jack_pat_q);
      tpt_pkg::REG_BUTTON_PAT: prdata = tpt_pkg::APB_DATA_W'(button_pat_q);
      default:                 prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Single-pass state update
  // ---------------------------------------------------------------------------
  assign accept = in_valid_i && !in_stall_o;

  // Shift an inactive pin in as 1, an active one as 0
  assign jack_shift   = {jack_hist_q[HW-2:0], ~level_i};
  assign button_shift = {button_hist_q[HW-2:0], ~level_i};

  // Compare only the low history bits of each pattern
  assign jack_pat_ext   = tpt_pkg::PAT_EXT_W'(jack_pat_q);
  assign button_pat_ext = tpt_pkg::PAT_EXT_W'(button_pat_q);

  tpt_tol_check u_tol_check (
    .capture_i (elapsed_q),
    .period_i  (period_q),
    .tol_i     (tol_q),
    .outside_o (outside)
  );

  always_comb begin
    jack_hist_d           = jack_hist_q;
    button_hist_d         = button_hist_q;
    elapsed_d             = elapsed_q;
    period_d              = period_q;
    result.ping_detected  = 1'b0;
    result.ping_source    = tpt_pkg::PING_JACK;
    result.period_adopted = 1'b0;

    unique case (tpt_pkg::req_type_e'(req_type_i))
      tpt_pkg::REQ_TICK: begin
        // Saturate at all ones
        if (elapsed_q != '1) begin
          elapsed_d = elapsed_q + CW'(1);
        end
      end
      tpt_pkg::REQ_JACK: begin
        jack_hist_d = jack_shift;
        if (jack_shift == jack_pat_ext[HW-1:0]) begin
          result.ping_detected = 1'b1;
          elapsed_d            = '0;
          // Adopt the capture only on a change beyond the tolerance band
          if (outside) begin
            period_d              = elapsed_q;
            result.period_adopted = 1'b1;
          end
        end
      end
      tpt_pkg::REQ_BUTTON: begin
        button_hist_d = button_shift;
        if (button_shift == button_pat_ext[HW-1:0]) begin
          result.ping_detected  = 1'b1;
          result.ping_source    = tpt_pkg::PING_BUTTON;
          result.period_adopted = 1'b1;
          period_d              = {elapsed_q[CW-1:3], 3'b000};
          elapsed_d             = '0;
        end
      end
      default: ;  // unused request code: hold everything
    endcase

    result.period_value = tpt_pkg::PERIOD_W'(period_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      jack_hist_q   <= '0;
      button_hist_q <= '0;
      elapsed_q     <= '0;
      period_q      <= '0;
    end else if (accept) begin
      jack_hist_q   <= jack_hist_d;
      button_hist_q <= button_hist_d;
      elapsed_q     <= elapsed_d;
      period_q      <= period_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register with skid entry
  // ---------------------------------------------------------------------------
  tpt_out_buf u_out_buf (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (in_valid_i),
    .push_stall_o (in_stall_o),
    .push_data_i  (result),
    .pop_valid_o  (out_valid_o),
    .pop_stall_i  (out_stall_i),
    .pop_data_o   (out_data)
  );

  assign ping_detected_o  = out_data.ping_detected;
  assign ping_source_o    = out_data.ping_source;
  assign period_adopted_o = out_data.period_adopted;
  assign period_value_o   = out_data.period_value;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // The period only moves on an accepted item that reports an adoption
  a_period_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(period_q) |-> $past(accept && result.period_adopted))
    else $error("period changed without an adopting transfer");

  // A detected ping restarts the elapsed count
  a_ping_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && result.ping_detected |=> elapsed_q == '0)
    else $error("elapsed count not cleared after ping");

  // Source and adoption flags stay low without a ping
  a_no_ping_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !ping_detected_o |-> !ping_source_o && !period_adopted_o)
    else $error("flags set on a result without a ping");

  // The input side stalls only while the output side holds a result
  a_stall_backed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with an empty result register");

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps

module tb;

  // Request code that the block must ignore
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  // Receiver hold-off that forces the block to fill up and stall its input
  localparam int LONG_HOLD   = 80;
  // Cycles without any transfer before the run is declared hung
  localparam int QUIET_LIMIT = 2000;

  typedef struct packed {
    logic [1:0] kind;
    logic       level;
  } tap_item_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                           psel    = 1'b0;
  logic                           penable = 1'b0;
  logic                           pwrite  = 1'b0;
  logic [tpt_pkg::APB_ADDR_W-1:0] paddr   = '0;
  logic [tpt_pkg::APB_DATA_W-1:0] pwdata  = '0;
  logic [tpt_pkg::APB_DATA_W-1:0] prdata;
  logic                           pready;

  logic                         in_valid_i  = 1'b0;
  logic                         in_stall_o;
  logic [1:0]                   req_type_i  = tpt_pkg::REQ_TICK;
  logic                         level_i     = 1'b0;
  logic                         out_valid_o;
  logic                         out_stall_i = 1'b0;
  logic                         ping_detected_o;
  logic                         ping_source_o;
  logic                         period_adopted_o;
  logic [tpt_pkg::PERIOD_W-1:0] period_value_o;

  // Items waiting to be offered, and results the block still owes us
  tap_item_t        pending_items[$];
  tpt_pkg::result_t expected_results[$];

  int   items_queued = 0;
  int   in_xfers     = 0;
  int   fail_count   = 0;
  logic in_fire      = 1'b0;

  // Idling knobs: 1-in-send_odds chance of a burst per sent item, 1-in-stall_odds per receiver check, 0 = never
  int   send_odds    = 0;
  int   stall_odds   = 0;
  logic calm         = 1'b0;
  int   holds_asked  = 0;

  // Local copy of the configuration registers
  logic [tpt_pkg::TOL_W-1:0]     cfg_tol        = tpt_pkg::TOL_RESET;
  logic [tpt_pkg::PATTERN_W-1:0] cfg_jack_pat   = tpt_pkg::JACK_PAT_RESET;
  logic [tpt_pkg::PATTERN_W-1:0] cfg_button_pat = tpt_pkg::BUTTON_PAT_RESET;

  // Tracker state mirrored from the block
  logic [tpt_pkg::HISTORY_BITS-1:0] jack_hist   = '0;
  logic [tpt_pkg::HISTORY_BITS-1:0] button_hist = '0;
  logic [tpt_pkg::COUNT_WIDTH-1:0]  tick_count  = '0;
  logic [tpt_pkg::PERIOD_W-1:0]     held_period = '0;

  tap_clock_period_tracker_core DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .req_type_i       (req_type_i),
    .level_i          (level_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .ping_detected_o  (ping_detected_o),
    .ping_source_o    (ping_source_o),
    .period_adopted_o (period_adopted_o),
    .period_value_o   (period_value_o)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Advance the mirrored tracker by one item and return the result it owes.
  // Pin samples shift in as 1 while the pin is inactive; a match on the jack
  // captures the tick count and keeps the old period unless the capture is
  // outside the tolerance band, checked as an exact integer cross-multiply.
  function automatic tpt_pkg::result_t track_item(input logic [1:0] kind, input logic lvl);
    tpt_pkg::result_t r;
    logic [63:0]      cap_w, per_w, tol_w, scaled, upper, lower;
    r = '0;
    case (kind)
      tpt_pkg::REQ_TICK: begin
        if (tick_count != '1) tick_count = tick_count + 1'b1;
      end
      tpt_pkg::REQ_JACK: begin
        jack_hist = {jack_hist[tpt_pkg::HISTORY_BITS-2:0], ~lvl};
        if (jack_hist == cfg_jack_pat) begin
          r.ping_detected = 1'b1;
          r.ping_source   = tpt_pkg::PING_JACK;
          cap_w  = 64'(tick_count);
          per_w  = 64'(held_period);
          tol_w  = 64'(cfg_tol);
          scaled = cap_w * 64'd100;
          upper  = per_w * (64'd100 + tol_w);
          lower  = per_w * (64'd100 - tol_w);
          if (scaled > upper || scaled < lower) begin
            held_period      = tick_count;
            r.period_adopted = 1'b1;
          end
          tick_count = '0;
        end
      end
      tpt_pkg::REQ_BUTTON: begin
        button_hist = {button_hist[tpt_pkg::HISTORY_BITS-2:0], ~lvl};
        if (button_hist == cfg_button_pat) begin
          r.ping_detected  = 1'b1;
          r.ping_source    = tpt_pkg::PING_BUTTON;
          r.period_adopted = 1'b1;
          // Drop the low three bits: a tapped period is a multiple of 8 ticks
          held_period = {tick_count[tpt_pkg::COUNT_WIDTH-1:3], 3'b000};
          tick_count  = '0;
        end
      end
      default: ;
    endcase
    r.period_value = held_period;
    return r;
  endfunction

  // Monitor: predict on every input transfer, check every result transfer.
  // Push the expectation before popping so a same-edge result still lines up.
  always @(posedge clk_i) begin : monitor
    tpt_pkg::result_t seen, want;
    in_fire <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      expected_results.push_back(track_item(req_type_i, level_i));
      in_xfers++;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen = {ping_detected_o, ping_source_o, period_adopted_o, period_value_o};
      if (expected_results.size() == 0) begin
        $error("result transfer with nothing expected: %p", seen);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (seen.ping_detected !== want.ping_detected) begin
          $error("ping_detected: expected %0d, got %0d", want.ping_detected,
                 seen.ping_detected);
          fail_count++;
        end
        if (seen.ping_source !== want.ping_source) begin
          $error("ping_source: expected %0d, got %0d", want.ping_source, seen.ping_source);
          fail_count++;
        end
        if (seen.period_adopted !== want.period_adopted) begin
          $error("period_adopted: expected %0d, got %0d", want.period_adopted,
                 seen.period_adopted);
          fail_count++;
        end
        if (seen.period_value !== want.period_value) begin
          $error("period_value: expected %0d, got %0d", want.period_value,
                 seen.period_value);
          fail_count++;
        end
      end
    end
  end

  // Driver: offer the next pending item once the current one is taken, or
  // idle for a random burst. Hold the payload while the block stalls.
  always @(negedge clk_i) begin : driver
    tap_item_t nxt;
    int        send_gap;
    if (rst_ni && (!in_valid_i || in_fire)) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (pending_items.size() != 0) begin
        nxt = pending_items.pop_front();
        req_type_i <= nxt.kind;
        level_i    <= nxt.level;
        in_valid_i <= 1'b1;
        if (!calm && send_odds != 0 && $urandom_range(send_odds - 1, 0) == 0)
          send_gap = $urandom_range(19, 1);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: random stall bursts, plus a long hold-off whenever one is asked
  always @(negedge clk_i) begin : receiver
    int holds_served;
    int hold_left;
    int stall_left;
    if (holds_served != holds_asked) begin
      holds_served++;
      hold_left = LONG_HOLD;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (!calm && stall_odds != 0 && $urandom_range(stall_odds - 1, 0) == 0) begin
      stall_left = $urandom_range(19, 1) - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Watchdog: end the run if no transfer happens on either channel for too long
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("Verification failed");
    $finish;
  end

  task automatic offer_item(input logic [1:0] kind, input logic lvl);
    tap_item_t it;
    it.kind  = kind;
    it.level = lvl;
    pending_items.push_back(it);
    items_queued++;
  endtask

  // Play one pattern into a source's history, MSB first, with the given number
  // of ticks spread in between. Now and then corrupt one sample or slip in a
  // sample of the other source to break the sequence.
  task automatic offer_pattern_run(input logic [1:0] kind,
                                   input logic [tpt_pkg::PATTERN_W-1:0] pat,
                                   input int ticks);
    int left, n, flip;
    left = ticks;
    flip = ($urandom_range(9, 0) == 0) ?
           int'($urandom_range(tpt_pkg::PATTERN_W - 1, 0)) : -1;
    for (int b = tpt_pkg::PATTERN_W - 1; b >= 0; b--) begin
      n = (b == 0) ? left : int'($urandom_range(left / 4, 0));
      left -= n;
      repeat (n) offer_item(tpt_pkg::REQ_TICK, 1'($urandom_range(1, 0)));
      if ($urandom_range(15, 0) == 0)
        offer_item((kind == tpt_pkg::REQ_JACK) ? tpt_pkg::REQ_BUTTON : tpt_pkg::REQ_JACK,
                   1'($urandom_range(1, 0)));
      offer_item(kind, ~pat[b] ^ (b == flip));
    end
  endtask

  // Random beats around a nominal period: mostly jack edges and button taps
  // whose spacing straddles the tolerance band, the rest plain noise.
  task automatic offer_beats(input int n_items, input int beat);
    int goal, jitter, ticks, pick;
    goal = items_queued + n_items;
    while (items_queued < goal) begin
      pick   = $urandom_range(99, 0);
      jitter = beat * int'(cfg_tol) / 100 + 2;
      ticks  = beat + int'($urandom_range(2 * jitter, 0)) - jitter;
      if (ticks < 0) ticks = 0;
      if (pick < 55)
        offer_pattern_run(tpt_pkg::REQ_JACK, cfg_jack_pat, ticks);
      else if (pick < 80)
        offer_pattern_run(tpt_pkg::REQ_BUTTON, cfg_button_pat, ticks);
      else
        repeat ($urandom_range(12, 1))
          offer_item(2'($urandom_range(3, 0)), 1'($urandom_range(1, 0)));
    end
  endtask

  // Wait until every queued item has been taken and every result checked
  task automatic drain();
    do @(negedge clk_i);
    while (!(in_xfers == items_queued && expected_results.size() == 0));
  endtask

  // APB write (setup then access), then read the register back
  task automatic set_register(input tpt_pkg::reg_idx_e idx,
                              input logic [tpt_pkg::APB_DATA_W-1:0] value);
    logic [tpt_pkg::APB_DATA_W-1:0] stored, got;
    stored = '0;
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    case (idx)
      tpt_pkg::REG_TOLERANCE: begin
        cfg_tol = value[tpt_pkg::TOL_W-1:0];
        stored[tpt_pkg::TOL_W-1:0] = cfg_tol;
      end
      tpt_pkg::REG_JACK_PAT: begin
        cfg_jack_pat = value[tpt_pkg::PATTERN_W-1:0];
        stored[tpt_pkg::PATTERN_W-1:0] = cfg_jack_pat;
      end
      tpt_pkg::REG_BUTTON_PAT: begin
        cfg_button_pat = value[tpt_pkg::PATTERN_W-1:0];
        stored[tpt_pkg::PATTERN_W-1:0] = cfg_button_pat;
      end
      default: ;
    endcase
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    got = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== stored) begin
      $error("register %s readback: expected %0d, got %0d", idx.name(), stored, got);
      fail_count++;
    end
  endtask

  initial begin
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: all-active patterns match on every active sample while the
    // histories are still clear from reset, so each ping costs one item.
    set_register(tpt_pkg::REG_JACK_PAT, '0);
    set_register(tpt_pkg::REG_BUTTON_PAT, '0);
    send_odds  = 4;
    stall_odds = 4;
    offer_item(REQ_UNUSED, 1'b0);                  // unused request type: no effect
    offer_item(REQ_UNUSED, 1'b1);
    offer_item(tpt_pkg::REQ_JACK, 1'b1);           // zero capture on zero period: kept
    offer_item(tpt_pkg::REQ_TICK, 1'b1);           // level is ignored on ticks
    offer_item(tpt_pkg::REQ_TICK, 1'b0);
    offer_item(tpt_pkg::REQ_TICK, 1'b1);
    offer_item(tpt_pkg::REQ_JACK, 1'b1);           // nonzero capture on zero period
    repeat (3) offer_item(tpt_pkg::REQ_TICK, 1'b0);
    offer_item(tpt_pkg::REQ_JACK, 1'b1);           // same capture: inside the band
    offer_item(tpt_pkg::REQ_JACK, 1'b1);           // zero capture on nonzero period
    repeat (11) offer_item(tpt_pkg::REQ_TICK, 1'b1);
    offer_item(tpt_pkg::REQ_BUTTON, 1'b1);         // tap: 11 rounds down to 8
    offer_item(tpt_pkg::REQ_BUTTON, 1'b0);         // release breaks the match
    offer_item(tpt_pkg::REQ_JACK, 1'b0);
    drain();

    // Reset patterns, zero tolerance: any change of spacing is adopted
    set_register(tpt_pkg::REG_TOLERANCE, 0);
    set_register(tpt_pkg::REG_JACK_PAT, tpt_pkg::JACK_PAT_RESET);
    set_register(tpt_pkg::REG_BUTTON_PAT, tpt_pkg::BUTTON_PAT_RESET);
    send_odds  = 6;
    stall_odds = 6;
    offer_beats(250, 20);
    drain();

    // Wide band with random patterns; hold the receiver off for a long
    // stretch while the sender keeps offering, so the block backs up.
    set_register(tpt_pkg::REG_TOLERANCE, 50);
    set_register(tpt_pkg::REG_JACK_PAT, $urandom_range(8191, 0));
    set_register(tpt_pkg::REG_BUTTON_PAT, $urandom_range(8191, 0));
    send_odds  = 20;
    stall_odds = 4;
    offer_beats(250, 40);
    holds_asked++;
    drain();

    // Widest tolerance and the extreme patterns, no idling on either side
    set_register(tpt_pkg::REG_TOLERANCE, 63);
    set_register(tpt_pkg::REG_JACK_PAT, 32'h1FFF);
    set_register(tpt_pkg::REG_BUTTON_PAT, '0);
    send_odds  = 0;
    stall_odds = 0;
    offer_beats(250, 12);
    drain();

    // Random settings with heavy idling
    set_register(tpt_pkg::REG_TOLERANCE, $urandom_range(63, 0));
    set_register(tpt_pkg::REG_JACK_PAT, $urandom_range(8191, 0));
    set_register(tpt_pkg::REG_BUTTON_PAT, $urandom_range(8191, 0));
    send_odds  = 3;
    stall_odds = 3;
    offer_beats(250, 30);
    drain();

    // Back to the reset tolerance and jack pattern; full rate to the end
    set_register(tpt_pkg::REG_TOLERANCE, tpt_pkg::APB_DATA_W'(tpt_pkg::TOL_RESET));
    set_register(tpt_pkg::REG_JACK_PAT, tpt_pkg::APB_DATA_W'(tpt_pkg::JACK_PAT_RESET));
    set_register(tpt_pkg::REG_BUTTON_PAT, $urandom_range(8191, 0));
    calm = 1'b1;
    offer_beats(300, 30);
    drain();

    // Give a stray result time to show up
    repeat (4) @(posedge clk_i);
    if (fail_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/tpt_pkg.sv
hdl/tpt_tol_check.sv
hdl/tpt_out_buf.sv
hdl/tap_clock_period_tracker_core.sv
test/tb.sv
